// ===== rtl/pbau_pkg.sv =====
package pbau_pkg;

	localparam int WORD_DIGITS = 8;
	localparam int CONV_DIGITS = 10;
	localparam int CONV_W = 4 * CONV_DIGITS;
	localparam int SIGN_POS = 31;

	localparam logic [2:0] FN_ADD   = 3'd0;
	localparam logic [2:0] FN_SUB   = 3'd1;
	localparam logic [2:0] FN_SSUB  = 3'd2;
	localparam logic [2:0] FN_B2D   = 3'd3;
	localparam logic [2:0] FN_D2B   = 3'd4;
	localparam logic [2:0] FN_CHECK = 3'd5;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
	} op_item_t;

	typedef struct packed {
		logic [31:0] result_word;
		logic        digits_valid;
		logic        carry_out;
	} res_item_t;

	// per-digit carry/borrow generate and propagate, with both candidate digits
	typedef struct packed {
		logic       g;
		logic       p;
		logic [3:0] d0;
		logic [3:0] d1;
	} dig_gp_t;

endpackage

// ===== rtl/packed_bcd_arithmetic_unit.sv =====
// Each op passes through the stage registers in order; its result on res_data is registered in the last stage.
// Throughput: one op per cycle; each stage holds when the one after it is full and stalled.
// The binary-to-BCD converter is four 8-bit shift-add-3 slices in stages 5 to 8.
// Reset: arst_n clears the stage valid bits only; no data state is kept between ops.
module packed_bcd_arithmetic_unit import pbau_pkg::*; #(
	parameter int DIGITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_ready,
	input  op_item_t  op_data,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res_data
);

	localparam int ND = (DIGITS < WORD_DIGITS) ? DIGITS : WORD_DIGITS;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	always_comb begin
		en_s8 = !v_s8 || res_ready;
		en_s7 = !v_s7 || en_s8;
		en_s6 = !v_s6 || en_s7;
		en_s5 = !v_s5 || en_s6;
		en_s4 = !v_s4 || en_s5;
		en_s3 = !v_s3 || en_s4;
		en_s2 = !v_s2 || en_s3;
		en_s1 = !v_s1 || en_s2;
	end

	assign op_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= op_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	// stage 1: digit generate/propagate, validity, digit pairs for BCD to binary
	dig_gp_t     dgp [WORD_DIGITS];
	logic [31:0] src_a;
	logic [31:0] src_b;
	logic        dv;
	logic [7:0]  pa [4];
	logic [7:0]  pb [4];

	for (genvar g = 0; g < WORD_DIGITS; g++) begin : g_pre
		pbau_digit_pre u_pre (
			.a_nib (op_data.operand_a[4*g +: 4]),
			.b_nib (op_data.operand_b[4*g +: 4]),
			.sub   (op_data.func == FN_SUB),
			.gp    (dgp[g])
		);
	end

	always_comb begin
		src_a = op_data.operand_a;
		src_b = op_data.operand_b;
		src_b[SIGN_POS] = 1'b0;
		if (op_data.func == FN_SSUB) begin
			src_a[SIGN_POS] = 1'b0;
		end
		dv = 1'b1;
		for (int i = 0; i < WORD_DIGITS; i++) begin
			if (i >= ND) begin
				src_a[4*i +: 4] = 4'd0;
				src_b[4*i +: 4] = 4'd0;
			end else if (op_data.operand_a[4*i +: 4] > 4'd9) begin
				dv = 1'b0;
			end
		end
		for (int k = 0; k < 4; k++) begin
			pa[k] = {4'd0, src_a[8*k +: 4]} + ({4'd0, src_a[8*k+4 +: 4]} << 3)
				+ ({4'd0, src_a[8*k+4 +: 4]} << 1);
			pb[k] = {4'd0, src_b[8*k +: 4]} + ({4'd0, src_b[8*k+4 +: 4]} << 3)
				+ ({4'd0, src_b[8*k+4 +: 4]} << 1);
		end
	end

	logic [2:0]  func_s1;
	logic [31:0] a_s1;
	logic        a_neg_s1, b_neg_s1, dv_s1;
	dig_gp_t     dgp_s1 [WORD_DIGITS];
	logic [7:0]  pa_s1 [4];
	logic [7:0]  pb_s1 [4];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			func_s1  <= op_data.func;
			a_s1     <= op_data.operand_a;
			a_neg_s1 <= op_data.operand_a[SIGN_POS];
			b_neg_s1 <= op_data.operand_b[SIGN_POS];
			dv_s1    <= dv;
			for (int i = 0; i < WORD_DIGITS; i++) begin
				dgp_s1[i] <= (i < ND) ? dgp[i] : '0;
			end
			for (int k = 0; k < 4; k++) begin
				pa_s1[k] <= pa[k];
				pb_s1[k] <= pb[k];
			end
		end
	end

	// stage 2: carry/borrow chain and digit select; digit quads
	logic [WORD_DIGITS:0] cy;
	logic [31:0]          as_res;

	always_comb begin
		cy[0] = 1'b0;
		for (int i = 0; i < WORD_DIGITS; i++) begin
			cy[i+1] = dgp_s1[i].g || (dgp_s1[i].p && cy[i]);
			as_res[4*i +: 4] = cy[i] ? dgp_s1[i].d1 : dgp_s1[i].d0;
		end
	end

	logic [2:0]  func_s2;
	logic [31:0] a_s2, as_res_s2;
	logic        a_neg_s2, b_neg_s2, dv_s2, as_cy_s2;
	logic [14:0] qa_s2 [2];
	logic [14:0] qb_s2 [2];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			func_s2   <= func_s1;
			a_s2      <= a_s1;
			a_neg_s2  <= a_neg_s1;
			b_neg_s2  <= b_neg_s1;
			dv_s2     <= dv_s1;
			as_res_s2 <= as_res;
			as_cy_s2  <= cy[ND];
			for (int k = 0; k < 2; k++) begin
				qa_s2[k] <= {7'd0, pa_s1[2*k]} + 15'({7'd0, pa_s1[2*k+1]} * 15'd100);
				qb_s2[k] <= {7'd0, pb_s1[2*k]} + 15'({7'd0, pb_s1[2*k+1]} * 15'd100);
			end
		end
	end

	// stage 3: binary values of both operands
	logic [2:0]  func_s3;
	logic [31:0] a_s3, as_res_s3;
	logic        a_neg_s3, b_neg_s3, dv_s3, as_cy_s3;
	logic [27:0] va_s3, vb_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			func_s3   <= func_s2;
			a_s3      <= a_s2;
			a_neg_s3  <= a_neg_s2;
			b_neg_s3  <= b_neg_s2;
			dv_s3     <= dv_s2;
			as_res_s3 <= as_res_s2;
			as_cy_s3  <= as_cy_s2;
			va_s3     <= {13'd0, qa_s2[0]} + 28'({13'd0, qa_s2[1]} * 28'd10000);
			vb_s3     <= {13'd0, qb_s2[0]} + 28'({13'd0, qb_s2[1]} * 28'd10000);
		end
	end

	// stage 4: signed difference, converter input, direct results
	logic [29:0] sa, sb, diff, mag;
	logic [31:0] conv;
	logic [31:0] dir_res;
	logic        dir_cy;

	always_comb begin
		sa   = a_neg_s3 ? (30'd0 - {2'd0, va_s3}) : {2'd0, va_s3};
		sb   = b_neg_s3 ? (30'd0 - {2'd0, vb_s3}) : {2'd0, vb_s3};
		diff = sa - sb;
		mag  = diff[29] ? (30'd0 - diff) : diff;
		conv = (func_s3 == FN_B2D) ? a_s3 : {3'd0, mag[28:0]};
		unique case (func_s3)
			FN_ADD, FN_SUB: begin
				dir_res = as_res_s3;
				dir_cy  = as_cy_s3;
			end
			FN_D2B: begin
				dir_res = {4'd0, va_s3};
				dir_cy  = 1'b0;
			end
			default: begin
				dir_res = 32'd0;
				dir_cy  = 1'b0;
			end
		endcase
	end

	logic [2:0]  func_s4;
	logic [31:0] conv_s4, dir_res_s4;
	logic        neg_s4, dv_s4, dir_cy_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			func_s4    <= func_s3;
			conv_s4    <= conv;
			neg_s4     <= diff[29];
			dv_s4      <= dv_s3;
			dir_res_s4 <= dir_res;
			dir_cy_s4  <= dir_cy;
		end
	end

	// stages 5 to 8: shift-add-3 conversion, one byte per stage
	logic [CONV_W-1:0] bcd5, bcd6, bcd7, bcd8;

	pbau_dd_slice u_dd5 (.bcd_in('0),     .bits(conv_s4[31:24]), .bcd_out(bcd5));

	logic [2:0]        func_s5, func_s6, func_s7;
	logic [23:0]       rest_s5;
	logic [15:0]       rest_s6;
	logic [7:0]        rest_s7;
	logic [CONV_W-1:0] bcd_s5, bcd_s6, bcd_s7;
	logic              neg_s5, neg_s6, neg_s7;
	logic              dv_s5, dv_s6, dv_s7;
	logic [31:0]       dir_res_s5, dir_res_s6, dir_res_s7;
	logic              dir_cy_s5, dir_cy_s6, dir_cy_s7;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			func_s5    <= func_s4;
			rest_s5    <= conv_s4[23:0];
			bcd_s5     <= bcd5;
			neg_s5     <= neg_s4;
			dv_s5      <= dv_s4;
			dir_res_s5 <= dir_res_s4;
			dir_cy_s5  <= dir_cy_s4;
		end
	end

	pbau_dd_slice u_dd6 (.bcd_in(bcd_s5), .bits(rest_s5[23:16]), .bcd_out(bcd6));

	always_ff @(posedge clk) begin
		if (en_s6) begin
			func_s6    <= func_s5;
			rest_s6    <= rest_s5[15:0];
			bcd_s6     <= bcd6;
			neg_s6     <= neg_s5;
			dv_s6      <= dv_s5;
			dir_res_s6 <= dir_res_s5;
			dir_cy_s6  <= dir_cy_s5;
		end
	end

	pbau_dd_slice u_dd7 (.bcd_in(bcd_s6), .bits(rest_s6[15:8]), .bcd_out(bcd7));

	always_ff @(posedge clk) begin
		if (en_s7) begin
			func_s7    <= func_s6;
			rest_s7    <= rest_s6[7:0];
			bcd_s7     <= bcd7;
			neg_s7     <= neg_s6;
			dv_s7      <= dv_s6;
			dir_res_s7 <= dir_res_s6;
			dir_cy_s7  <= dir_cy_s6;
		end
	end

	pbau_dd_slice u_dd8 (.bcd_in(bcd_s7), .bits(rest_s7), .bcd_out(bcd8));

	logic [31:0] low;
	logic        drop;
	res_item_t   res_next;
	res_item_t   res_s8;

	always_comb begin
		low  = bcd8[31:0];
		drop = 1'b0;
		for (int d = 0; d < CONV_DIGITS; d++) begin
			if (d >= ND) begin
				drop = drop || (bcd8[4*d +: 4] != 4'd0);
			end
		end
		for (int i = 0; i < WORD_DIGITS; i++) begin
			if (i >= ND) begin
				low[4*i +: 4] = 4'd0;
			end
		end
		res_next.digits_valid = dv_s7;
		unique case (func_s7)
			FN_B2D: begin
				res_next.result_word = low;
				res_next.carry_out   = drop;
			end
			FN_SSUB: begin
				res_next.result_word = {neg_s7, low[30:0]};
				res_next.carry_out   = drop || low[SIGN_POS];
			end
			default: begin
				res_next.result_word = dir_res_s7;
				res_next.carry_out   = dir_cy_s7;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			res_s8 <= res_next;
		end
	end

	assign res_valid = v_s8;
	assign res_data  = res_s8;

endmodule

// ===== rtl/pbau_digit_pre.sv =====
module pbau_digit_pre import pbau_pkg::*; (
	input  logic [3:0] a_nib,
	input  logic [3:0] b_nib,
	input  logic       sub,
	output dig_gp_t    gp
);

	logic [4:0] s0;
	logic [4:0] s1;
	logic [4:0] t1;
	logic [4:0] diff0;
	logic [4:0] diff1;

	always_comb begin
		s0    = {1'b0, a_nib} + {1'b0, b_nib};
		s1    = s0 + 5'd1;
		t1    = {1'b0, b_nib} + 5'd1;
		diff0 = {1'b0, a_nib} - {1'b0, b_nib};
		diff1 = {1'b0, a_nib} - t1;
		if (sub) begin
			gp.g  = diff0[4];
			gp.p  = diff1[4];
			gp.d0 = diff0[3:0] + (diff0[4] ? 4'd10 : 4'd0);
			gp.d1 = diff1[3:0] + (diff1[4] ? 4'd10 : 4'd0);
		end else begin
			gp.g  = (s0 > 5'd9);
			gp.p  = (s1 > 5'd9);
			gp.d0 = s0[3:0] + ((s0 > 5'd9) ? 4'd6 : 4'd0);
			gp.d1 = s1[3:0] + ((s1 > 5'd9) ? 4'd6 : 4'd0);
		end
	end

endmodule

// ===== rtl/pbau_dd_slice.sv =====
module pbau_dd_slice import pbau_pkg::*; (
	input  logic [CONV_W-1:0] bcd_in,
	input  logic [7:0]        bits,
	output logic [CONV_W-1:0] bcd_out
);

	logic [CONV_W-1:0] acc;

	always_comb begin
		acc = bcd_in;
		for (int j = 7; j >= 0; j--) begin
			for (int d = 0; d < CONV_DIGITS; d++) begin
				if (acc[4*d +: 4] >= 4'd5) begin
					acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
				end
			end
			acc = {acc[CONV_W-2:0], bits[j]};
		end
		bcd_out = acc;
	end

endmodule

// ===== tb/sv/packed_bcd_arithmetic_unit_tb.sv =====
`timescale 1ns / 100ps

module packed_bcd_arithmetic_unit_tb import pbau_pkg::*;;

	localparam int DIGITS = 8;
	localparam int ND = (DIGITS < 8) ? DIGITS : 8;
	localparam int LATENCY = 8;
	localparam int LONG_HOLD = 200;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [2:0] FN_RSVD6 = 3'd6;
	localparam logic [2:0] FN_RSVD7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic op_valid;
	logic op_ready;
	op_item_t op_data;
	logic res_valid;
	logic res_ready;
	res_item_t res_data;

	res_item_t pending_results[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit src_gaps = 1'b0;
	bit sink_gaps = 1'b0;
	bit long_hold_req = 1'b0;

	packed_bcd_arithmetic_unit #(.DIGITS(DIGITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_ready(op_ready),
		.op_data(op_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned bcd_weighted(logic [31:0] w);
		longint unsigned acc;
		longint unsigned wt;
		acc = 0;
		wt = 1;
		for (int i = 0; i < ND; i++) begin
			acc += w[4*i +: 4] * wt;
			wt *= 10;
		end
		return acc;
	endfunction

	function automatic logic [31:0] to_packed_bcd(longint unsigned v, output logic lost);
		logic [31:0] r;
		longint unsigned rest;
		r = '0;
		rest = v;
		for (int i = 0; i < ND; i++) begin
			r[4*i +: 4] = 4'(rest % 10);
			rest = rest / 10;
		end
		lost = (rest != 0);
		return r;
	endfunction

	function automatic res_item_t bcd_unit_result(op_item_t op);
		res_item_t res;
		int x, t, s, cy;
		longint sa, sb, diff;
		longint unsigned mag;
		logic [31:0] r;
		logic lost;
		res.result_word = '0;
		res.carry_out = 1'b0;
		res.digits_valid = 1'b1;
		for (int i = 0; i < ND; i++)
			if (op.operand_a[4*i +: 4] > 9)
				res.digits_valid = 1'b0;
		case (op.func)
			FN_ADD: begin
				cy = 0;
				for (int i = 0; i < ND; i++) begin
					s = op.operand_a[4*i +: 4] + op.operand_b[4*i +: 4] + cy;
					if (s > 9) begin
						s = (s + 6) & 'hf;
						cy = 1;
					end else begin
						cy = 0;
					end
					res.result_word[4*i +: 4] = s[3:0];
				end
				res.carry_out = cy[0];
			end
			FN_SUB: begin
				cy = 0;
				for (int i = 0; i < ND; i++) begin
					x = int'(op.operand_a[4*i +: 4]);
					t = op.operand_b[4*i +: 4] + cy;
					if (x < t) begin
						s = (x + 26 - t) & 'hf;
						cy = 1;
					end else begin
						s = x - t;
						cy = 0;
					end
					res.result_word[4*i +: 4] = s[3:0];
				end
				res.carry_out = cy[0];
			end
			FN_SSUB: begin
				sa = longint'(bcd_weighted({1'b0, op.operand_a[SIGN_POS-1:0]}));
				sb = longint'(bcd_weighted({1'b0, op.operand_b[SIGN_POS-1:0]}));
				if (op.operand_a[SIGN_POS])
					sa = -sa;
				if (op.operand_b[SIGN_POS])
					sb = -sb;
				diff = sa - sb;
				mag = (diff < 0) ? longint'(-diff) : diff;
				r = to_packed_bcd(mag, lost);
				if (r[SIGN_POS]) begin
					lost = 1'b1;
					r[SIGN_POS] = 1'b0;
				end
				if (diff < 0)
					r[SIGN_POS] = 1'b1;
				res.result_word = r;
				res.carry_out = lost;
			end
			FN_B2D: begin
				res.result_word = to_packed_bcd(longint'(op.operand_a), lost);
				res.carry_out = lost;
			end
			FN_D2B: begin
				res.result_word = 32'(bcd_weighted(op.operand_a));
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic logic [31:0] rand_bcd(int unsigned ndig);
		logic [31:0] w;
		w = '0;
		for (int i = 0; i < ndig; i++)
			w[4*i +: 4] = 4'($urandom_range(0, 9));
		return w;
	endfunction

	function automatic logic [31:0] rand_operand(logic [2:0] func);
		int unsigned pick;
		int unsigned pos;
		logic [31:0] w;
		pick = $urandom_range(0, 15);
		if (func == FN_B2D && pick < 6)
			return $urandom_range(0, 150000000);
		if (func == FN_B2D && pick < 8)
			return $urandom_range(99999900, 100000100);
		case (pick)
			0, 1: return $urandom();
			2: begin
				case ($urandom_range(0, 5))
					0: return 32'h0000_0000;
					1: return 32'h9999_9999;
					2: return 32'h8000_0000;
					3: return 32'h7fff_ffff;
					4: return 32'hffff_ffff;
					default: return 32'h0000_0001;
				endcase
			end
			3: begin
				w = rand_bcd(8);
				pos = $urandom_range(0, 7);
				w[4*pos +: 4] = 4'($urandom_range(10, 15));
				return w;
			end
			default: return rand_bcd($urandom_range(1, 8));
		endcase
	endfunction

	// hold valid and payload until the transfer
	task automatic send_op(logic [2:0] func, logic [31:0] a, logic [31:0] b);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			op_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		op_valid <= 1'b1;
		op_data.func <= func;
		op_data.operand_a <= a;
		op_data.operand_b <= b;
		do
			@(posedge clk);
		while (!op_ready);
	endtask

	task automatic send_random_op();
		int unsigned r;
		logic [2:0] func;
		r = $urandom_range(0, 19);
		func = (r < 18) ? 3'(r % 6) : ((r == 18) ? FN_RSVD6 : FN_RSVD7);
		send_op(func, rand_operand(func), rand_operand(func));
	endtask

	task automatic wait_drained();
		op_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_corner_cases();
		send_op(FN_ADD, 32'h9999_9999, 32'h0000_0001);
		send_op(FN_ADD, 32'h0000_0000, 32'h0000_0000);
		send_op(FN_ADD, 32'hffff_ffff, 32'hffff_ffff);
		send_op(FN_SUB, 32'h0000_0000, 32'h0000_0001);
		send_op(FN_SUB, 32'h1234_5678, 32'h1234_5678);
		send_op(FN_SUB, 32'hfafa_fafa, 32'h0f0f_0f0f);
		send_op(FN_SSUB, 32'h0000_0005, 32'h8000_0003);
		send_op(FN_SSUB, 32'h8000_0000, 32'h0000_0000);
		send_op(FN_SSUB, 32'h0000_0000, 32'h8000_0000);
		send_op(FN_SSUB, 32'h7999_9999, 32'h8000_0001);
		send_op(FN_SSUB, 32'h7fff_ffff, 32'hffff_ffff);
		send_op(FN_SSUB, 32'h8000_0002, 32'h0000_0009);
		send_op(FN_B2D, 32'd0, 32'h0);
		send_op(FN_B2D, 32'd99999999, 32'h0);
		send_op(FN_B2D, 32'd100000000, 32'h0);
		send_op(FN_B2D, 32'hffff_ffff, 32'hffff_ffff);
		send_op(FN_D2B, 32'h9999_9999, 32'h0);
		send_op(FN_D2B, 32'hffff_ffff, 32'h0);
		send_op(FN_D2B, 32'h0000_0000, 32'hffff_ffff);
		send_op(FN_CHECK, 32'h0999_9999, 32'h0);
		send_op(FN_CHECK, 32'h0000_000a, 32'hffff_ffff);
		send_op(FN_RSVD6, 32'hffff_ffff, 32'hffff_ffff);
		send_op(FN_RSVD7, 32'h1234_5678, 32'h8765_4321);
		wait_drained();
	endtask

	task automatic test_random_mix();
		for (int blk = 0; blk < 6; blk++) begin
			src_gaps = (blk % 3) != 1;
			sink_gaps = (blk % 3) != 2;
			repeat (100) send_random_op();
			wait_drained();
		end
	endtask

	task automatic test_output_stall();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		long_hold_req = 1'b1;
		repeat (60) send_random_op();
		wait_drained();
	endtask

	task automatic test_full_rate();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		repeat (320) send_random_op();
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		op_valid <= 1'b0;
		op_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_random_mix();
		test_output_stall();
		test_full_rate();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		res_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				res_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
				res_ready <= 1'b1;
			end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				res_ready <= 1'b1;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && op_valid && op_ready)
			pending_results.push_back(bcd_unit_result(op_data));
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no transfer pending: %h", res_data);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_data.result_word !== want.result_word) begin
					$error("result_word: expected %h, got %h",
						want.result_word, res_data.result_word);
					mismatch_count++;
				end
				if (res_data.digits_valid !== want.digits_valid) begin
					$error("digits_valid: expected %b, got %b",
						want.digits_valid, res_data.digits_valid);
					mismatch_count++;
				end
				if (res_data.carry_out !== want.carry_out) begin
					$error("carry_out: expected %b, got %b",
						want.carry_out, res_data.carry_out);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((op_valid && op_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
